// ===== hw/rtl/seven_segment_mux_driver_core_assert.svh =====
// Assertion macros shared by the display driver RTL.
// Arguments: label, clock, active-low reset, antecedent, consequent, message.
`ifndef SEVEN_SEGMENT_MUX_DRIVER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_CORE_ASSERT_SVH
`ifndef SYNTH
// consequent checked in the same cycle
`define SSMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent checked in the next cycle
`define SSMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SSMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ssmd_pkg.sv =====
package ssmd_pkg;

    localparam int NUMBER_W   = 14;
    localparam int FUNC_W     = 3;
    localparam int SEL_W      = 3;
    localparam int SEG_W      = 7;
    localparam int DRIVE_W    = SEG_W + 1;   // segments plus decimal point
    localparam int CODE_W     = 4;
    localparam int DEC_DIGITS = 4;           // value is shown modulo 10000

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_BLANK = 4'd15;
    localparam t_code CODE_EIGHT = 4'd8;

    // Reciprocal multiply constants, exact for every 14-bit value.
    localparam int RECIP_W = 15;
    localparam int PROD_W  = NUMBER_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 15'd16778;
    localparam logic [RECIP_W-1:0] RECIP_100  = 15'd20972;
    localparam logic [RECIP_W-1:0] RECIP_10   = 15'd26215;
    localparam int SHIFT_1000 = 24;
    localparam int SHIFT_100  = 21;
    localparam int SHIFT_10   = 18;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_SHOW   = 3'd1,
        FUNC_CLEAR  = 3'd2,
        FUNC_TEST   = 3'd3,
        FUNC_DP_SET = 3'd4,
        FUNC_DP_CLR = 3'd5,
        FUNC_SELECT = 3'd6
    } t_func;

    typedef struct packed {
        logic             fire;
        t_func            func;
        logic [SEL_W-1:0] sel;
    } t_cmd;

    function automatic logic [SEG_W-1:0] seg_pattern(input t_code code);
        logic [SEG_W-1:0] pat;
        case (code)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = '0;   // blank and unused codes
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/ssmd_split.sv =====
module ssmd_split #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic [ssmd_pkg::NUMBER_W-1:0] i_number,
    output ssmd_pkg::t_code               o_codes [DIGIT_COUNT]
);
    import ssmd_pkg::*;

    localparam int Q1000_W = PROD_W - SHIFT_1000;
    localparam int Q100_W  = PROD_W - SHIFT_100;
    localparam int Q10_W   = PROD_W - SHIFT_10;

    logic [PROD_W-1:0]   w_p1000, w_p100, w_p10;
    logic [Q1000_W-1:0]  w_q1000, w_thou;
    logic [Q100_W-1:0]   w_q100, w_hund;
    logic [Q10_W-1:0]    w_q10, w_tens;
    logic [NUMBER_W-1:0] w_ones;
    t_code               w_dec [DEC_DIGITS];
    t_code               w_raw [DIGIT_COUNT];

    // n/1000, n/100, n/10 in parallel
    assign w_p1000 = PROD_W'(i_number) * PROD_W'(RECIP_1000);
    assign w_p100  = PROD_W'(i_number) * PROD_W'(RECIP_100);
    assign w_p10   = PROD_W'(i_number) * PROD_W'(RECIP_10);
    assign w_q1000 = w_p1000[PROD_W-1:SHIFT_1000];
    assign w_q100  = w_p100[PROD_W-1:SHIFT_100];
    assign w_q10   = w_p10[PROD_W-1:SHIFT_10];

    // thousands digit is (n/1000) mod 10, quotient stays below 17
    assign w_thou = (w_q1000 >= Q1000_W'(10)) ? (w_q1000 - Q1000_W'(10)) : w_q1000;
    assign w_hund = w_q100 - Q100_W'(w_q1000) * Q100_W'(10);
    assign w_tens = w_q10 - Q10_W'(w_q100) * Q10_W'(10);
    assign w_ones = i_number - NUMBER_W'(w_q10) * NUMBER_W'(10);

    assign w_dec[0] = w_ones[CODE_W-1:0];
    assign w_dec[1] = w_tens[CODE_W-1:0];
    assign w_dec[2] = w_hund[CODE_W-1:0];
    assign w_dec[3] = w_thou[CODE_W-1:0];

    // ones digit lands in the last position
    for (genvar gi = 0; gi < DIGIT_COUNT; gi++) begin : g_pos
        if (DIGIT_COUNT - 1 - gi < DEC_DIGITS) begin : g_dec
            assign w_raw[gi] = w_dec[DIGIT_COUNT-1-gi];
        end else begin : g_zero
            assign w_raw[gi] = '0;
        end
    end

    // leading zero blanking, ones digit always shown
    always_comb begin
        logic v_seen;
        v_seen = 1'b0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (w_raw[i] != '0 || v_seen || i == DIGIT_COUNT - 1) begin
                o_codes[i] = w_raw[i];
                v_seen     = 1'b1;
            end else begin
                o_codes[i] = CODE_BLANK;
            end
        end
    end

endmodule

// ===== hw/rtl/ssmd_display.sv =====
`include "seven_segment_mux_driver_core_assert.svh"

module ssmd_display #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssmd_pkg::t_cmd                 i_cmd,
    input  ssmd_pkg::t_code                i_show_codes [DIGIT_COUNT],
    input  logic                           i_on_level,
    output logic [ssmd_pkg::DRIVE_W-1:0]   o_segment_drive,
    output logic [DIGIT_COUNT-1:0]         o_digit_drive
);
    import ssmd_pkg::*;

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    t_code               r_codes [DIGIT_COUNT];
    t_code               n_codes [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] r_point_flags, n_point_flags;
    logic [POS_W-1:0]    r_scan_pos, n_scan_pos;
    logic [DRIVE_W-1:0]  r_segment_drive, n_segment_drive;
    logic [DIGIT_COUNT-1:0] r_digit_drive, n_digit_drive;

    logic [DRIVE_W-1:0]     w_on_segs;
    logic [DIGIT_COUNT-1:0] w_cur_onehot;
    logic [POS_W-1:0]       w_scan_next;
    logic [POS_W-1:0]       w_sel_pos;

    assign w_on_segs    = {r_point_flags[r_scan_pos], seg_pattern(r_codes[r_scan_pos])};
    assign w_cur_onehot = DIGIT_COUNT'(1) << r_scan_pos;
    assign w_scan_next  = (r_scan_pos == POS_W'(DIGIT_COUNT - 1)) ? '0
                                                                   : r_scan_pos + POS_W'(1);
    assign w_sel_pos    = (32'(i_cmd.sel) > 32'(DIGIT_COUNT - 1)) ? '0 : POS_W'(i_cmd.sel);

    always_comb begin
        n_codes         = r_codes;
        n_point_flags   = r_point_flags;
        n_scan_pos      = r_scan_pos;
        n_segment_drive = r_segment_drive;
        n_digit_drive   = r_digit_drive;
        if (i_cmd.fire) begin
            case (i_cmd.func)
                FUNC_TICK: begin
                    // current common off, others on
                    n_segment_drive = i_on_level ? w_on_segs : ~w_on_segs;
                    n_digit_drive   = i_on_level ? ~w_cur_onehot : w_cur_onehot;
                    n_scan_pos      = w_scan_next;
                end
                FUNC_SHOW: begin
                    n_codes = i_show_codes;
                end
                FUNC_CLEAR: begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        n_codes[i] = CODE_BLANK;
                    end
                    n_point_flags   = '0;
                    n_segment_drive = {DRIVE_W{~i_on_level}};
                    n_digit_drive   = {DIGIT_COUNT{~i_on_level}};
                end
                FUNC_TEST: begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        n_codes[i] = CODE_EIGHT;
                    end
                    n_point_flags = '1;
                end
                FUNC_DP_SET: begin
                    n_point_flags[r_scan_pos] = 1'b1;
                end
                FUNC_DP_CLR: begin
                    n_point_flags[r_scan_pos] = 1'b0;
                end
                FUNC_SELECT: begin
                    n_scan_pos = w_sel_pos;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_codes[i] <= CODE_BLANK;
            end
            r_point_flags   <= '0;
            r_scan_pos      <= '0;
            r_segment_drive <= '0;
            r_digit_drive   <= '0;
        end else begin
            r_codes         <= n_codes;
            r_point_flags   <= n_point_flags;
            r_scan_pos      <= n_scan_pos;
            r_segment_drive <= n_segment_drive;
            r_digit_drive   <= n_digit_drive;
        end
    end

    assign o_segment_drive = r_segment_drive;
    assign o_digit_drive   = r_digit_drive;

    `SSMD_ASSERT_NEXT(a_pins_hold, i_clk, i_rst_n, !i_cmd.fire, $stable(r_segment_drive) && $stable(r_digit_drive), "pins changed with no command")
    `SSMD_ASSERT_NEXT(a_tick_one_digit, i_clk, i_rst_n, i_cmd.fire && i_cmd.func == FUNC_TICK, $onehot(r_digit_drive ^ {DIGIT_COUNT{$past(i_on_level)}}), "tick must leave exactly one common off")
    `SSMD_ASSERT_NEXT(a_clear_all_off, i_clk, i_rst_n, i_cmd.fire && i_cmd.func == FUNC_CLEAR, r_point_flags == '0 && (&(r_digit_drive ^ {DIGIT_COUNT{$past(i_on_level)}})), "clear left a point or common on")

endmodule

// ===== hw/rtl/seven_segment_mux_driver_core.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// request   | i_valid / o_ready      | i_func, i_number, i_digit_select
// result    | o_valid / i_ready      | o_segment_lines, o_point_line, o_digit_lines
// config    | i_cfg_wr_en (no wait)  | i_cfg_wr_data = on_level
//
// One request per cycle sustained while the result channel is not stalled; a
// request passes through the request register, then the display state / pin
// registers, before its result is on the outputs.
// The pin registers double as the result register: a request is applied only
// when the result slot is empty or being drained, so a stalled result holds.
// Synchronous active-low reset: display blank, pins low, on_level high.
// No reset sweep; the block takes requests right after reset.
`include "seven_segment_mux_driver_core_assert.svh"

module seven_segment_mux_driver_core #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ssmd_pkg::FUNC_W-1:0]    i_func,
    input  logic [ssmd_pkg::NUMBER_W-1:0]  i_number,
    input  logic [ssmd_pkg::SEL_W-1:0]     i_digit_select,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ssmd_pkg::SEG_W-1:0]     o_segment_lines,
    output logic                           o_point_line,
    output logic [DIGIT_COUNT-1:0]         o_digit_lines,
    // on_level register
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data
);
    import ssmd_pkg::*;

    // request register
    logic                r_in_valid, n_in_valid;
    logic [FUNC_W-1:0]   r_func;
    logic [NUMBER_W-1:0] r_number;
    logic [SEL_W-1:0]    r_digit_select;

    logic                r_out_valid, n_out_valid;
    logic                r_on_level;

    logic                w_fire;     // request moves into display state
    logic                w_take;     // new request captured
    t_cmd                w_cmd;
    t_code               w_show_codes [DIGIT_COUNT];
    logic [DRIVE_W-1:0]  w_segment_drive;
    logic [DIGIT_COUNT-1:0] w_digit_drive;

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_on_level  <= 1'b1;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_on_level <= i_cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func         <= i_func;
            r_number       <= i_number;
            r_digit_select <= i_digit_select;
        end
    end

    assign w_cmd.fire = w_fire;
    assign w_cmd.func = t_func'(r_func);
    assign w_cmd.sel  = r_digit_select;

    // decimal split of the held number, used by show only
    ssmd_split #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_split (
        .i_number (r_number),
        .o_codes  (w_show_codes)
    );

    ssmd_display #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_display (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_show_codes    (w_show_codes),
        .i_on_level      (r_on_level),
        .o_segment_drive (w_segment_drive),
        .o_digit_drive   (w_digit_drive)
    );

    assign o_valid         = r_out_valid;
    assign o_segment_lines = w_segment_drive[SEG_W-1:0];
    assign o_point_line    = w_segment_drive[SEG_W];
    assign o_digit_lines   = w_digit_drive;

    `SSMD_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_valid, "applied request produced no result")

endmodule
